// ===== rtl/pprc_pkg.sv =====
// Package for the point-pair rigidity check: widths, reset values, state
// encoding and the command/status structs between controller and datapath.
// No dependencies.
`timescale 1ns / 1ps

package pprc_pkg;

    localparam int COORD_BITS_DEF = 24;
    localparam int AXES           = 3;
    localparam int DIST_BITS      = 26;
    localparam logic [DIST_BITS-1:0] DIST_MAX       = '1;
    localparam logic [DIST_BITS-1:0] MIN_DIST_RESET = 26'd1311;
    localparam int ROOT_BITS      = DIST_BITS + 1;
    localparam int RAD_BITS       = 2 * ROOT_BITS;
    localparam int REM_BITS       = ROOT_BITS + 3;
    localparam int PROD_BITS      = 2 * DIST_BITS;
    localparam int CNT_BITS       = 5;
    localparam int OUT_DATA_BITS  = ((DIST_BITS + 1 + 7) / 8) * 8;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_ACC,
        ST_ROOT,
        ST_UPDATE,
        ST_REPORT
    } t_state;

    typedef struct packed {
        logic       load;
        logic       mul;
        logic       acc;
        logic       root_step;
        logic       update;
        logic       report;
        logic [1:0] axis;
    } t_cmd;

    typedef struct packed {
        logic last;
        logic out_free;
    } t_status;

endpackage

// ===== rtl/pprc_ctrl.sv =====
// Controller for the point-pair rigidity check: sequences load, squaring,
// accumulation, the bit-serial square root, min/max update and report.
// Depends on pprc_pkg.
`timescale 1ns / 1ps

module pprc_ctrl
    import pprc_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_s_tvalid,
    output logic    o_s_tready,
    input  t_status i_status,
    output t_cmd    o_cmd
);

    t_state               r_state, n_state;
    logic [CNT_BITS-1:0]  r_cnt, n_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        unique case (r_state)
            ST_IDLE: begin
                if (i_s_tvalid) begin
                    n_state = ST_MUL;
                    n_cnt   = '0;
                end
            end
            ST_MUL: n_state = ST_ACC;
            ST_ACC: begin
                if (r_cnt == CNT_BITS'(AXES - 1)) begin
                    n_state = ST_ROOT;
                    n_cnt   = '0;
                end else begin
                    n_state = ST_MUL;
                    n_cnt   = r_cnt + 1'b1;
                end
            end
            ST_ROOT: begin
                if (r_cnt == CNT_BITS'(ROOT_BITS - 1)) begin
                    n_state = ST_UPDATE;
                    n_cnt   = '0;
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end
            ST_UPDATE: n_state = i_status.last ? ST_REPORT : ST_IDLE;
            ST_REPORT: begin
                if (i_status.out_free) n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_cmd      = '0;
        o_s_tready = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                o_s_tready = 1'b1;
                o_cmd.load = i_s_tvalid;
            end
            ST_MUL: begin
                o_cmd.mul  = 1'b1;
                o_cmd.axis = r_cnt[1:0];
            end
            ST_ACC:    o_cmd.acc       = 1'b1;
            ST_ROOT:   o_cmd.root_step = 1'b1;
            ST_UPDATE: o_cmd.update    = 1'b1;
            ST_REPORT: o_cmd.report    = i_status.out_free;
            default:   o_cmd           = '0;
        endcase
    end

    a_root_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ST_ROOT |-> r_cnt < CNT_BITS'(ROOT_BITS))
        else $error("root step count out of range");
    a_load_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.load |=> r_state == ST_MUL && r_cnt == '0)
        else $error("accepted item did not start squaring");
    a_axis_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ST_ACC || r_state == ST_MUL |-> r_cnt < CNT_BITS'(AXES))
        else $error("axis index out of range");

endmodule

// ===== rtl/pprc_dpath.sv =====
// Datapath for the point-pair rigidity check: coordinate differences,
// shared squarer, accumulator, bit-serial square root, min/max, result register.
// Depends on pprc_pkg.
`timescale 1ns / 1ps

module pprc_dpath
    import pprc_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  t_cmd                        i_cmd,
    output t_status                     o_status,
    input  logic [6*COORD_BITS-1:0]     i_coord,
    input  logic                        i_last,
    input  logic                        i_cfg_valid,
    input  logic [DIST_BITS-1:0]        i_cfg_data,
    input  logic                        i_m_tready,
    output logic                        o_m_tvalid,
    output logic [OUT_DATA_BITS-1:0]    o_m_tdata
);

    localparam int AW    = COORD_BITS + 1;
    localparam int EW    = (AW > DIST_BITS) ? AW : DIST_BITS;
    localparam int OUT_PAD = OUT_DATA_BITS - DIST_BITS - 1;

    logic [DIST_BITS-1:0]  r_diff [AXES];
    logic                  r_sat;
    logic                  r_last;
    logic [PROD_BITS-1:0]  r_prod;
    logic [RAD_BITS-1:0]   r_acc;
    logic [REM_BITS-1:0]   r_rem;
    logic [ROOT_BITS-1:0]  r_root;
    logic [DIST_BITS-1:0]  r_least;
    logic [DIST_BITS-1:0]  r_greatest;
    logic [DIST_BITS-1:0]  r_thresh;
    logic [DIST_BITS-1:0]  r_spread;
    logic                  r_rigid;
    logic                  r_m_valid;

    logic [EW-1:0]         abs_ext [AXES];
    logic                  n_sat;
    logic [DIST_BITS-1:0]  mul_op;
    logic [REM_BITS-1:0]   rem_sh;
    logic [REM_BITS-1:0]   trial;
    logic [DIST_BITS-1:0]  pair_dist;
    logic [DIST_BITS-1:0]  spread;
    logic                  out_free;

    always_comb begin
        logic signed [AW-1:0] ca, cb, df;
        logic [AW-1:0]        mag;
        n_sat = 1'b0;
        for (int k = 0; k < AXES; k++) begin
            ca = AW'($signed(i_coord[k*COORD_BITS +: COORD_BITS]));
            cb = AW'($signed(i_coord[(k+AXES)*COORD_BITS +: COORD_BITS]));
            df = ca - cb;
            mag = df[AW-1] ? AW'(-df) : AW'(df);
            abs_ext[k] = EW'(mag);
            if (abs_ext[k] >= EW'(DIST_MAX)) n_sat = 1'b1;
        end
    end

    always_comb begin
        case (i_cmd.axis)
            2'd0:    mul_op = r_diff[0];
            2'd1:    mul_op = r_diff[1];
            2'd2:    mul_op = r_diff[2];
            default: mul_op = '0;
        endcase
    end

    assign rem_sh    = {r_rem[REM_BITS-3:0], r_acc[RAD_BITS-1 -: 2]};
    assign trial     = REM_BITS'({r_root, 2'b01});
    assign pair_dist = (r_sat || r_root[ROOT_BITS-1]) ? DIST_MAX : r_root[DIST_BITS-1:0];
    assign spread    = r_greatest - r_least;
    assign out_free  = !r_m_valid || i_m_tready;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            for (int k = 0; k < AXES; k++) r_diff[k] <= abs_ext[k][DIST_BITS-1:0];
            r_sat  <= n_sat;
            r_last <= i_last;
            r_acc  <= '0;
            r_rem  <= '0;
            r_root <= '0;
        end else if (i_cmd.mul) begin
            r_prod <= mul_op * mul_op;
        end else if (i_cmd.acc) begin
            r_acc <= r_acc + RAD_BITS'(r_prod);
        end else if (i_cmd.root_step) begin
            r_acc <= {r_acc[RAD_BITS-3:0], 2'b00};
            if (rem_sh >= trial) begin
                r_rem  <= rem_sh - trial;
                r_root <= {r_root[ROOT_BITS-2:0], 1'b1};
            end else begin
                r_rem  <= rem_sh;
                r_root <= {r_root[ROOT_BITS-2:0], 1'b0};
            end
        end
        if (i_cmd.report) begin
            r_spread <= spread;
            r_rigid  <= (spread <= r_thresh);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_least    <= DIST_MAX;
            r_greatest <= '0;
            r_thresh   <= MIN_DIST_RESET;
            r_m_valid  <= 1'b0;
        end else begin
            if (i_cfg_valid) r_thresh <= i_cfg_data;
            if (i_cmd.update) begin
                if (pair_dist < r_least)    r_least    <= pair_dist;
                if (pair_dist > r_greatest) r_greatest <= pair_dist;
            end else if (i_cmd.report) begin
                r_least    <= DIST_MAX;
                r_greatest <= '0;
            end
            if (i_cmd.report)    r_m_valid <= 1'b1;
            else if (i_m_tready) r_m_valid <= 1'b0;
        end
    end

    assign o_status.last     = r_last;
    assign o_status.out_free = out_free;
    assign o_m_tvalid        = r_m_valid;
    assign o_m_tdata         = {{OUT_PAD{1'b0}}, r_spread, r_rigid};

    a_clear_after_report: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.report |=> r_least == DIST_MAX && r_greatest == '0)
        else $error("run state not cleared after report");
    a_order_after_update: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.update |=> r_least <= r_greatest)
        else $error("least distance above greatest after update");
    a_report_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.report |=> r_m_valid && r_spread == $past(spread))
        else $error("report did not load the result register");

endmodule

// ===== rtl/point_pair_rigidity_check.sv =====
// Top level of the point-pair rigidity check: joins controller and datapath.
// Depends on pprc_pkg, pprc_ctrl, pprc_dpath.
//
//   channel  dir  handshake              payload
//   s        in   i_s_tvalid/o_s_tready  i_s_tdata ax..bz, i_s_tlast last
//   m        out  o_m_tvalid/i_m_tready  o_m_tdata rigid, spread
//   cfg      in   i_cfg_valid/o_cfg_ready i_cfg_data min_distance
//
// An item runs from acceptance to the next accept through load, the shared
// squarer and accumulator once per axis (three axes), the square root at one
// bit per cycle and the min/max update. An item with tlast adds a report
// step, held while the result register is still full. Reset clears control,
// sets the threshold to 1311 and the run to empty; no clearing pass. A result
// still waiting in the result register holds the report, and with it the input.
`timescale 1ns / 1ps

module point_pair_rigidity_check
    import pprc_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_s_tvalid,
    output logic                                 o_s_tready,
    // ax, ay, az, bx, by_coord, bz from bit 0 up, zero padding on top
    input  logic [((6*COORD_BITS+7)/8)*8-1:0]    i_s_tdata,
    input  logic                                 i_s_tlast,
    output logic                                 o_m_tvalid,
    input  logic                                 i_m_tready,
    // rigid, spread from bit 0 up, zero padding on top
    output logic [OUT_DATA_BITS-1:0]             o_m_tdata,
    input  logic                                 i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  logic [DIST_BITS-1:0]                 i_cfg_data
);

    t_cmd    cmd;
    t_status status;

    assign o_cfg_ready = 1'b1;

    pprc_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    pprc_dpath #(
        .COORD_BITS (COORD_BITS)
    ) u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_status    (status),
        .i_coord     (i_s_tdata[6*COORD_BITS-1:0]),
        .i_last      (i_s_tlast),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_data  (i_cfg_data),
        .i_m_tready  (i_m_tready),
        .o_m_tvalid  (o_m_tvalid),
        .o_m_tdata   (o_m_tdata)
    );

endmodule

// ===== tb/sv/testbench.sv =====
// Testbench for point_pair_rigidity_check: directed and random runs of frames,
// each result checked against a predictor of distance spread and rigid flag.
// Depends on pprc_pkg and the point_pair_rigidity_check RTL.
`timescale 1ns / 1ps

module testbench;
    import pprc_pkg::*;

    localparam int     CB            = COORD_BITS_DEF;
    localparam int     IN_DATA_BITS  = ((6 * CB + 7) / 8) * 8;
    localparam int     SETTLE_CYCLES = 48;
    localparam int     HOLD_CYCLES   = 600;
    localparam int     MAX_REPORTS   = 200;
    localparam longint CYCLE_LIMIT   = 600000;

    typedef struct packed {
        logic signed [CB-1:0] bz;
        logic signed [CB-1:0] by_coord;
        logic signed [CB-1:0] bx;
        logic signed [CB-1:0] az;
        logic signed [CB-1:0] ay;
        logic signed [CB-1:0] ax;
    } t_frame;

    typedef struct packed {
        logic [DIST_BITS-1:0] spread;
        logic                 rigid;
    } t_verdict;

    logic                     i_clk     = 1'b0;
    logic                     i_rst_n   = 1'b0;
    logic                     s_valid   = 1'b0;
    logic [IN_DATA_BITS-1:0]  s_data    = '0;
    logic                     s_last    = 1'b0;
    logic                     m_ready   = 1'b0;
    logic                     cfg_valid = 1'b0;
    logic [DIST_BITS-1:0]     cfg_data  = '0;
    logic                     o_s_tready;
    logic                     o_m_tvalid;
    logic [OUT_DATA_BITS-1:0] o_m_tdata;
    logic                     o_cfg_ready;

    logic [DIST_BITS-1:0] threshold    = MIN_DIST_RESET;
    logic [DIST_BITS-1:0] run_least    = DIST_MAX;
    logic [DIST_BITS-1:0] run_greatest = '0;
    t_verdict             pending_verdicts[$];
    int                   fault_count  = 0;
    int                   items_sent   = 0;
    int                   hold_left    = 0;
    int                   stall_left   = 0;
    bit                   idle_on      = 1'b1;
    longint               cycle_count  = 0;

    point_pair_rigidity_check #(
        .COORD_BITS (CB)
    ) uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (s_valid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (s_data),
        .i_s_tlast   (s_last),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (m_ready),
        .o_m_tdata   (o_m_tdata),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (cfg_data)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("testbench: errors");
        $finish;
    end

    function automatic longint unsigned axis_gap(input logic signed [CB-1:0] p,
                                                 input logic signed [CB-1:0] q);
        longint d;
        d = longint'(p) - longint'(q);
        return (d < 0) ? longint'(-d) : longint'(d);
    endfunction

    function automatic logic [DIST_BITS-1:0] frame_distance(input t_frame f);
        longint unsigned dx, dy, dz, rad, root, trial;
        dx = axis_gap(f.ax, f.bx);
        dy = axis_gap(f.ay, f.by_coord);
        dz = axis_gap(f.az, f.bz);
        if (dx >= DIST_MAX || dy >= DIST_MAX || dz >= DIST_MAX)
            return DIST_MAX;
        rad  = dx * dx + dy * dy + dz * dz;
        root = 0;
        for (int i = DIST_BITS - 1; i >= 0; i--) begin
            trial = root | (64'd1 << i);
            if (trial * trial <= rad)
                root = trial;
        end
        return root[DIST_BITS-1:0];
    endfunction

    function automatic t_frame make_frame(input int ax, input int ay, input int az,
                                          input int bx, input int by_c, input int bz);
        t_frame f;
        f.ax       = CB'(ax);
        f.ay       = CB'(ay);
        f.az       = CB'(az);
        f.bx       = CB'(bx);
        f.by_coord = CB'(by_c);
        f.bz       = CB'(bz);
        return f;
    endfunction

    function automatic int spread_int(input int span);
        return int'($urandom_range(0, 2 * span)) - span;
    endfunction

    function automatic logic [DIST_BITS-1:0] pick_threshold();
        case ($urandom_range(0, 4))
            0: return '0;
            1: return DIST_MAX;
            2: return DIST_BITS'($urandom_range(0, 2000));
            3: return DIST_BITS'($urandom);
            default: return DIST_BITS'($urandom_range(0, 200));
        endcase
    endfunction

    task automatic track_frame(input t_frame f, input logic ends_run);
        logic [DIST_BITS-1:0] d;
        t_verdict             v;
        d = frame_distance(f);
        if (d < run_least)
            run_least = d;
        if (d > run_greatest)
            run_greatest = d;
        if (ends_run) begin
            v.spread = run_greatest - run_least;
            v.rigid  = (v.spread <= threshold);
            pending_verdicts.push_back(v);
            run_least    = DIST_MAX;
            run_greatest = '0;
        end
    endtask

    task automatic report_mismatch(input string detail);
        if (fault_count < MAX_REPORTS)
            $display("mismatch at cycle %0d: %s", cycle_count, detail);
        fault_count++;
    endtask

    task automatic check_verdict(input logic [OUT_DATA_BITS-1:0] data);
        t_verdict got, want;
        got = data[DIST_BITS:0];
        if (pending_verdicts.size() == 0) begin
            report_mismatch($sformatf("unexpected item rigid=%0d spread=%0d",
                                      got.rigid, got.spread));
            return;
        end
        want = pending_verdicts.pop_front();
        if (got.rigid !== want.rigid)
            report_mismatch($sformatf("rigid %0d, want %0d", got.rigid, want.rigid));
        if (got.spread !== want.spread)
            report_mismatch($sformatf("spread %0d, want %0d", got.spread, want.spread));
    endtask

    initial begin
        forever begin
            @(posedge i_clk);
            if (o_m_tvalid && m_ready)
                check_verdict(o_m_tdata);
            if (hold_left > 0) begin
                hold_left = hold_left - 1;
                m_ready <= 1'b0;
            end else if (stall_left > 0) begin
                stall_left = stall_left - 1;
                m_ready <= 1'b0;
            end else if (idle_on && $urandom_range(0, 9) == 0) begin
                stall_left = $urandom_range(1, 17) - 1;
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    task automatic send_frame(input t_frame f, input logic ends_run);
        if (idle_on && $urandom_range(0, 5) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 17)) @(posedge i_clk);
        end
        s_valid <= 1'b1;
        s_data  <= IN_DATA_BITS'(f);
        s_last  <= ends_run;
        @(posedge i_clk);
        while (!o_s_tready) @(posedge i_clk);
        track_frame(f, ends_run);
        items_sent++;
    endtask

    task automatic wait_drained();
        s_valid <= 1'b0;
        while (pending_verdicts.size() != 0) @(posedge i_clk);
    endtask

    task automatic write_threshold(input logic [DIST_BITS-1:0] value);
        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        threshold = value;
        cfg_valid <= 1'b0;
    endtask

    // shaped runs translate both points together, with jitter on the second one
    task automatic send_run(input int frames, input bit shaped, input int jitter);
        int     ox, oy, oz, px, py, pz, tx, ty, tz;
        t_frame f;
        ox = spread_int(1 << 20);
        oy = spread_int(1 << 20);
        oz = spread_int(1 << 20);
        px = spread_int(1 << 21);
        py = spread_int(1 << 21);
        pz = spread_int(1 << 21);
        for (int k = 0; k < frames; k++) begin
            if (shaped) begin
                tx = px + spread_int(1 << 21);
                ty = py + spread_int(1 << 21);
                tz = pz + spread_int(1 << 21);
                f  = make_frame(tx, ty, tz,
                                tx + ox + spread_int(jitter),
                                ty + oy + spread_int(jitter),
                                tz + oz + spread_int(jitter));
            end else begin
                f = make_frame($urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
            end
            send_frame(f, k == frames - 1);
        end
    endtask

    task automatic test_reset_threshold();
        send_frame(make_frame(0, 0, 0, 0, 0, 0), 1'b0);
        send_frame(make_frame(0, 0, 0, 1311, 0, 0), 1'b1);
        send_frame(make_frame(0, 0, 0, 0, 0, 0), 1'b0);
        send_frame(make_frame(0, 0, 0, 0, 0, 1312), 1'b1);
    endtask

    task automatic test_coordinate_extremes();
        int lo, hi;
        lo = -(1 << (CB - 1));
        hi = (1 << (CB - 1)) - 1;
        send_frame(make_frame(lo, lo, lo, hi, hi, hi), 1'b1);
        send_frame(make_frame(hi, hi, hi, lo, lo, lo), 1'b1);
        send_frame(make_frame(hi, lo, hi, hi, lo, hi), 1'b1);
        send_frame(make_frame(24'h555555, 24'haaaaaa, 24'h555555,
                              24'haaaaaa, 24'h555555, 24'haaaaaa), 1'b1);
        send_frame(make_frame(lo, hi, lo, hi, lo, hi), 1'b0);
        send_frame(make_frame(3, 4, 1, 0, 0, 0), 1'b1);
    endtask

    task automatic test_threshold_limits();
        int lo, hi;
        lo = -(1 << (CB - 1));
        hi = (1 << (CB - 1)) - 1;
        write_threshold(DIST_BITS'(5));
        send_frame(make_frame(0, 0, 0, 10, 0, 0), 1'b0);
        send_frame(make_frame(0, 0, 0, 0, 15, 0), 1'b1);
        send_frame(make_frame(0, 0, 0, 10, 0, 0), 1'b0);
        send_frame(make_frame(0, 0, 0, 0, 0, -16), 1'b1);
        write_threshold('0);
        send_frame(make_frame(0, 0, 0, 7, 0, 0), 1'b0);
        send_frame(make_frame(5, 5, 5, 5, 12, 5), 1'b1);
        send_frame(make_frame(0, 0, 0, 7, 0, 0), 1'b0);
        send_frame(make_frame(0, 0, 0, 8, 0, 0), 1'b1);
        write_threshold(DIST_MAX);
        send_frame(make_frame(lo, lo, lo, hi, hi, hi), 1'b0);
        send_frame(make_frame(hi, hi, hi, hi, hi, hi), 1'b1);
    endtask

    task automatic test_random_runs(input int target, input bit reconfigure);
        int goal, frames, jitter;
        goal = items_sent + target;
        while (items_sent < goal) begin
            if (reconfigure && $urandom_range(0, 11) == 0)
                write_threshold(pick_threshold());
            frames = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 30)
                                                 : $urandom_range(1, 8);
            case ($urandom_range(0, 2))
                0: jitter = 0;
                1: jitter = $urandom_range(0, 64);
                default: jitter = $urandom_range(0, 600);
            endcase
            send_run(frames, $urandom_range(0, 9) < 7, jitter);
            if ($urandom_range(0, 15) == 0)
                wait_drained();
            if (reconfigure && $urandom_range(0, 20) == 0)
                idle_on = !idle_on;
        end
    endtask

    task automatic test_result_backpressure();
        idle_on   = 1'b1;
        hold_left = HOLD_CYCLES;
        repeat (8)
            send_frame(make_frame($urandom, $urandom, $urandom,
                                  $urandom, $urandom, $urandom), 1'b1);
        wait_drained();
    endtask

    task automatic test_steady_stream(input int target);
        idle_on = 1'b0;
        test_random_runs(target, 1'b0);
    endtask

    initial begin
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_reset_threshold();
        test_coordinate_extremes();
        test_threshold_limits();
        test_random_runs(700, 1'b1);
        test_result_backpressure();
        test_steady_stream(80);
        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (fault_count == 0)
            $display("testbench: clean");
        else
            $display("testbench: errors");
        $finish;
    end

endmodule
